// File: sv/m3inv_pkg.sv
package m3inv_pkg;

    // Item geometry and datapath widths
    localparam int N_LANE  = 9;
    localparam int EW      = 32;        // entry width, Q16.16
    localparam int TW      = 31;        // threshold width
    localparam int MW      = 65;        // 2x2 minor, Q32.32
    localparam int PW      = 65;        // partial product of a det term
    localparam int DW      = 99;        // determinant, Q48.48
    localparam int RW      = DW + 1;    // division remainder
    localparam int QW      = 32;        // quotient bits kept
    localparam int N_DIV   = QW;        // one quotient bit per stage
    localparam int N_FRONT = 5;         // stages ahead of the divider
    localparam int N_VLD   = N_FRONT + 1 + N_DIV + 1;   // front, magnitude, divider, output

    localparam logic [TW-1:0] THR_RESET = TW'(1);
    localparam logic [EW-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [EW-1:0] SAT_NEG   = 32'h8000_0000;

    // Minor for each output lane, in output order: x*y - u*v over flat a[0..8].
    // Odd lanes carry the cofactor sign flip.
    localparam logic [3:0] C_IX [N_LANE] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
    localparam logic [3:0] C_IY [N_LANE] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
    localparam logic [3:0] C_IU [N_LANE] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};
    localparam logic [3:0] C_IV [N_LANE] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};

    // Lanes holding the first-row minors used by the determinant
    localparam logic [3:0] C_DL [3] = '{4'd0, 4'd3, 4'd6};

    // Divider stage contents
    typedef struct packed {
        logic                      sing;
        logic [DW-1:0]             dmag;
        logic [N_LANE-1:0]         neg;
        logic [N_LANE-1:0]         ovf;
        logic [N_LANE-1:0][RW-1:0] rem;
        logic [N_LANE-1:0][QW-1:0] quo;
    } t_div;

    // One restoring step: {quotient bit, new remainder}
    function automatic logic [RW:0] div_step(logic [RW-1:0] rem, logic [DW-1:0] d);
        logic [RW-1:0] t;
        t = {rem[RW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            return {1'b1, t - {1'b0, d}};
        end else begin
            return {1'b0, t};
        end
    endfunction

endpackage

// File: sv/m3inv_if.sv
// Matrix request channel
interface m3inv_mat_if;
    logic        valid;
    logic        ready;
    logic [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

// Inverse result channel
interface m3inv_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic        singular;
    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                    inv22, singular, input ready);
    modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                    inv22, singular, output ready);
endinterface

// Threshold write channel
interface m3inv_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: sv/matrix3_inverse.sv
// Channel   Dir  Payload                          Request
// i_mat     in   a00..a22, signed Q16.16          valid & ready
// o_res     out  inv00..inv22 Q16.16, singular    valid & ready
// i_cfg     in   data = singular threshold        valid & ready (ready always 1)
//
// Stages from request to result: 5 front (input, products, minors, det partial
// products, det), 1 magnitude/threshold, 32 divider (one restoring quotient bit
// per stage for all nine lanes), 1 output. One matrix per cycle sustained while
// o_res is not stalled. Reset sets the threshold to 1 and clears all valid
// bits. A stall on o_res freezes the whole pipe; i_mat.ready drops with it.
module matrix3_inverse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    m3inv_mat_if.sink            i_mat,
    m3inv_res_if.source          o_res,
    m3inv_cfg_if.sink            i_cfg
);

    localparam int NL = m3inv_pkg::N_LANE;
    localparam int EW = m3inv_pkg::EW;
    localparam int MW = m3inv_pkg::MW;
    localparam int PW = m3inv_pkg::PW;
    localparam int DW = m3inv_pkg::DW;
    localparam int RW = m3inv_pkg::RW;
    localparam int QW = m3inv_pkg::QW;
    localparam int ND = m3inv_pkg::N_DIV;
    localparam int NV = m3inv_pkg::N_VLD;

    logic [m3inv_pkg::TW-1:0] r_thr;
    logic [NV-1:0]            r_vld;
    logic                     w_en;

    logic signed [EW-1:0]     w_a   [NL];
    logic signed [EW-1:0]     r_a   [NL];
    logic signed [2*EW-1:0]   r_pxy [NL];
    logic signed [2*EW-1:0]   r_puv [NL];
    logic signed [EW-1:0]     r_a0_1 [3];
    logic signed [EW-1:0]     r_a0_2 [3];
    logic signed [MW-1:0]     r_mn  [NL];
    logic signed [MW-1:0]     r_mn3 [NL];
    logic signed [MW-1:0]     r_mn4 [NL];
    logic signed [PW-1:0]     r_plo [3];
    logic signed [PW-1:0]     r_phi [3];
    logic signed [DW-1:0]     r_det;
    logic signed [DW-1:0]     n_det;
    m3inv_pkg::t_div          r_dv  [ND+1];
    m3inv_pkg::t_div          n_dv0;
    m3inv_pkg::t_div          n_dv  [ND];     // next value of r_dv[k+1]
    logic [EW-1:0]            n_res [NL];
    logic [EW-1:0]            r_res [NL];
    logic                     r_sing;

    // Whole pipe advances unless the result register is held
    assign w_en        = !r_vld[NV-1] || o_res.ready;
    assign i_mat.ready = w_en;
    assign i_cfg.ready = 1'b1;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= m3inv_pkg::THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    // Valid bits ride alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_mat.valid};
        end
    end

    assign w_a[0] = i_mat.a00;
    assign w_a[1] = i_mat.a01;
    assign w_a[2] = i_mat.a02;
    assign w_a[3] = i_mat.a10;
    assign w_a[4] = i_mat.a11;
    assign w_a[5] = i_mat.a12;
    assign w_a[6] = i_mat.a20;
    assign w_a[7] = i_mat.a21;
    assign w_a[8] = i_mat.a22;

    // Front stages: input, minor products, minors, det partial products, det
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                r_a[i]   <= w_a[i];
                r_pxy[i] <= (2*EW)'(r_a[m3inv_pkg::C_IX[i]]) *
                            (2*EW)'(r_a[m3inv_pkg::C_IY[i]]);
                r_puv[i] <= (2*EW)'(r_a[m3inv_pkg::C_IU[i]]) *
                            (2*EW)'(r_a[m3inv_pkg::C_IV[i]]);
                r_mn[i]  <= MW'(r_pxy[i]) - MW'(r_puv[i]);
                r_mn3[i] <= r_mn[i];
                r_mn4[i] <= r_mn3[i];
            end
            for (int j = 0; j < 3; j++) begin
                r_a0_1[j] <= r_a[j];
                r_a0_2[j] <= r_a0_1[j];
                r_plo[j]  <= PW'(r_a0_2[j]) *
                             PW'($signed({1'b0, r_mn[m3inv_pkg::C_DL[j]][31:0]}));
                r_phi[j]  <= PW'(r_a0_2[j]) *
                             PW'($signed(r_mn[m3inv_pkg::C_DL[j]][MW-1:32]));
            end
            r_det <= n_det;
        end
    end

    // Determinant along the first row, middle term negated
    always_comb begin
        logic signed [DW-1:0] t [3];
        for (int j = 0; j < 3; j++) begin
            t[j] = (DW'(r_phi[j]) <<< 32) + DW'(r_plo[j]);
        end
        n_det = t[0] - t[1] + t[2];
    end

    // Magnitudes, signs, threshold and overflow checks
    always_comb begin
        logic          dneg;
        logic [DW-1:0] dmag;
        logic [MW-1:0] cmag;
        logic          cneg;
        dneg = r_det[DW-1];
        dmag = dneg ? DW'(-r_det) : DW'(r_det);
        n_dv0.sing = DW'({r_thr, 32'd0}) >= dmag;
        n_dv0.dmag = dmag;
        for (int i = 0; i < NL; i++) begin
            cneg = r_mn4[i][MW-1];
            cmag = cneg ? MW'(-r_mn4[i]) : MW'(r_mn4[i]);
            n_dv0.neg[i] = cneg ^ i[0] ^ dneg;
            n_dv0.ovf[i] = DW'(cmag) >= dmag;
            n_dv0.rem[i] = RW'(cmag);
            n_dv0.quo[i] = '0;
        end
    end

    // Divider step logic: one quotient bit per stage, nine lanes side by side
    always_comb begin
        logic [RW:0] s;
        for (int k = 0; k < ND; k++) begin
            n_dv[k] = r_dv[k];
            for (int i = 0; i < NL; i++) begin
                s = m3inv_pkg::div_step(r_dv[k].rem[i], r_dv[k].dmag);
                n_dv[k].rem[i] = s[RW-1:0];
                n_dv[k].quo[i] = {r_dv[k].quo[i][QW-2:0], s[RW]};
            end
        end
    end

    // Divider stage registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0] <= n_dv0;
            for (int k = 1; k <= ND; k++) begin
                r_dv[k] <= n_dv[k-1];
            end
        end
    end

    // Sign, saturation, singular zeroing
    always_comb begin
        logic [QW-1:0] q;
        for (int i = 0; i < NL; i++) begin
            q = r_dv[ND].quo[i];
            if (r_dv[ND].sing) begin
                n_res[i] = '0;
            end else if (r_dv[ND].neg[i]) begin
                n_res[i] = (r_dv[ND].ovf[i] || q > m3inv_pkg::SAT_NEG) ?
                           m3inv_pkg::SAT_NEG : EW'(-q);
            end else begin
                n_res[i] = (r_dv[ND].ovf[i] || q > m3inv_pkg::SAT_POS) ?
                           m3inv_pkg::SAT_POS : q;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                r_res[i] <= n_res[i];
            end
            r_sing <= r_dv[ND].sing;
        end
    end

    assign o_res.valid    = r_vld[NV-1];
    assign o_res.inv00    = r_res[0];
    assign o_res.inv01    = r_res[1];
    assign o_res.inv02    = r_res[2];
    assign o_res.inv10    = r_res[3];
    assign o_res.inv11    = r_res[4];
    assign o_res.inv12    = r_res[5];
    assign o_res.inv20    = r_res[6];
    assign o_res.inv21    = r_res[7];
    assign o_res.inv22    = r_res[8];
    assign o_res.singular = r_sing;

    // Singular results carry zero entries (checked on inv00, inv11, inv22, inv01, inv12)
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.singular |-> o_res.inv00 == 0 && o_res.inv11 == 0 &&
        o_res.inv22 == 0 && o_res.inv01 == 0 && o_res.inv12 == 0)
        else $error("singular result with nonzero entries");

    // Last divider stage reaches the output on an advance
    a_last_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NV-2] && w_en |=> o_res.valid)
        else $error("result lost at output register");

    // A held result keeps the pipe frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> $stable(r_vld))
        else $error("pipe moved during output stall");

endmodule
